@@ src/spf_pkg.sv @@
// Package with shared types, constants and action codes of the polygon span filler.
package spf_pkg;
  localparam int unsigned MaxVertices = 32;
  localparam int unsigned CoordBits   = 10;
  localparam int unsigned IdxBits     = $clog2(MaxVertices);
  localparam int unsigned CntBits     = $clog2(MaxVertices + 1);
  localparam int unsigned SpanLimit   = 16;
  localparam int unsigned DivBits     = 2 * CoordBits + 1;

  localparam logic [1:0] ActClear = 2'd0;
  localparam logic [1:0] ActAdd   = 2'd1;
  localparam logic [1:0] ActFill  = 2'd2;
  localparam logic [1:0] ActNop   = 2'd3;

  typedef struct packed {
    logic [1:0]           action;
    logic [CoordBits-1:0] x_coord;
    logic [CoordBits-1:0] y_coord;
  } spf_in_t;

  typedef struct packed {
    logic [CoordBits-1:0] row;
    logic [CoordBits-1:0] x_start;
    logic [CoordBits-1:0] x_end;
    logic                 last_span;
  } spf_out_t;

  typedef struct packed {
    logic                        start;
    logic                        neg;
    logic [2*CoordBits-1:0]      num_mag;
    logic [CoordBits-1:0]        den_mag;
  } spf_div_req_t;
endpackage

@@ src/spf_divider.sv @@
// Restoring serial divider that gives a floor quotient of a signed numerator by a positive denominator.
module spf_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spf_pkg::spf_div_req_t             req_i,
  output logic                              done_o,
  output logic signed [spf_pkg::DivBits-1:0] quot_o
);
  import spf_pkg::*;

  localparam int unsigned NumBits = 2 * CoordBits;
  localparam int unsigned StepBits = $clog2(NumBits + 1);

  logic [NumBits-1:0]   num_q, num_d;
  logic [CoordBits:0]   rem_q, rem_d;
  logic [CoordBits-1:0] den_q, den_d;
  logic                 neg_q, neg_d;
  logic [StepBits-1:0]  step_q, step_d;
  logic                 run_q, run_d, done_q, done_d;
  logic [CoordBits+1:0] trial;
  logic [NumBits:0]     qmag;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[NumBits-1]} - {2'b00, den_q};
    if (req_i.start) begin
      num_d  = req_i.num_mag;
      den_d  = req_i.den_mag;
      neg_d  = req_i.neg;
      rem_d  = '0;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (!trial[CoordBits+1]) begin
        rem_d = trial[CoordBits:0];
        num_d = {num_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[CoordBits-1:0], num_q[NumBits-1]};
        num_d = {num_q[NumBits-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == StepBits'(NumBits - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    qmag = {1'b0, num_q};
    if (neg_q) begin
      quot_o = -$signed(qmag) - ((rem_q != '0) ? DivBits'(1) : DivBits'(0));
    end else begin
      quot_o = $signed(qmag);
    end
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end
endmodule

@@ src/scanline_polygon_span_fill.sv @@
// Top level of the polygon span filler: vertex store, edge walk, sort and span output.
//  channel | ports                     | handshake
//  command | start_i, busy_o, in_i     | beat taken when start_i is high and busy_o low
//  result  | out_valid_o, out_o        | one-cycle strobe, taken at the closing edge
// Clear and append pass through the done state back to idle. A fill reads each edge's two
// vertices, runs each crossing through the serial divider, then compare-swap sorts the k
// crossings, then emits the spans, one span per cycle.
// Reset empties the vertex list; the vertex memory itself is not cleared.
// The receiver cannot stall; spans leave one per cycle.
module scanline_polygon_span_fill (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  spf_pkg::spf_in_t  in_i,
  output logic              busy_o,
  output logic              out_valid_o,
  output spf_pkg::spf_out_t out_o
);
  import spf_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRd0   = 4'd1;
  localparam logic [3:0] StRd1   = 4'd2;
  localparam logic [3:0] StEdge  = 4'd3;
  localparam logic [3:0] StDiv   = 4'd4;
  localparam logic [3:0] StSort  = 4'd5;
  localparam logic [3:0] StEmit  = 4'd6;
  localparam logic [3:0] StDone  = 4'd7;
  localparam logic [3:0] StRdA   = 4'd8;

  logic [3:0]           st_q, st_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [IdxBits-1:0]   ei_q, ei_d;
  logic [CntBits-1:0]   k_q, k_d;
  logic [CntBits-1:0]   si_q, si_d, sj_q, sj_d;
  logic [CoordBits-1:0] yrow_q, yrow_d;
  logic [CoordBits-1:0] vx_mem [MaxVertices];
  logic [CoordBits-1:0] vy_mem [MaxVertices];
  logic [CoordBits-1:0] cr_q [MaxVertices];
  logic [IdxBits-1:0]   raddr;
  logic [CoordBits-1:0] rx_q, ry_q, x0_q, y0_q, x0_d, y0_d;
  logic                 wr_en;
  logic                 cr_wr, sw_en;
  logic [CoordBits-1:0] cr_wdata;
  logic [4:0]           span_q, span_d, nspan;
  logic                 done_div;
  logic signed [DivBits-1:0] quot;
  spf_div_req_t         dreq;
  logic signed [CoordBits+1:0] dx, dy, dyy;
  logic signed [2*CoordBits+3:0] prod;
  logic                 crosses;
  logic [IdxBits-1:0]   nxt;
  logic                 ov_d, ov_q;
  spf_out_t             o_d, o_q;

  assign wr_en = (st_q == StIdle) && start_i && in_i.action == ActAdd
                 && cnt_q < CntBits'(MaxVertices);
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vx_mem[cnt_q[IdxBits-1:0]] <= in_i.x_coord;
      vy_mem[cnt_q[IdxBits-1:0]] <= in_i.y_coord;
    end
    rx_q <= vx_mem[raddr];
    ry_q <= vy_mem[raddr];
  end

  assign nxt = (CntBits'(ei_q) + 1'b1 < cnt_q) ? ei_q + 1'b1 : '0;
  assign raddr = (st_q == StRd0 || st_q == StIdle) ? ei_q : nxt;

  assign dx  = $signed({2'b00, rx_q}) - $signed({2'b00, x0_q});
  assign dy  = $signed({2'b00, ry_q}) - $signed({2'b00, y0_q});
  assign dyy = $signed({2'b00, yrow_q}) - $signed({2'b00, y0_q});
  assign prod = dx * dyy;
  assign crosses = (y0_q <= yrow_q && ry_q > yrow_q) || (y0_q > yrow_q && ry_q <= yrow_q);

  always_comb begin
    dreq.start   = (st_q == StEdge) && crosses;
    dreq.neg     = prod[2*CoordBits+3] ^ dy[CoordBits+1];
    dreq.num_mag = prod[2*CoordBits+3] ? (2*CoordBits)'(-prod) : prod[2*CoordBits-1:0];
    dreq.den_mag = dy[CoordBits+1] ? CoordBits'(-dy) : dy[CoordBits-1:0];
  end

  spf_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (done_div),
    .quot_o (quot)
  );

  assign nspan = (k_q[CntBits-1:1] > CntBits'(SpanLimit)) ? 5'(SpanLimit)
                                                             : 5'(k_q[CntBits-1:1]);
  assign sw_en = (st_q == StSort) && (cr_q[sj_q[IdxBits-1:0]] > cr_q[sj_q[IdxBits-1:0]+1'b1]);

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; ei_d = ei_q; k_d = k_q; si_d = si_q; sj_d = sj_q;
    yrow_d = yrow_q; x0_d = x0_q; y0_d = y0_q; span_d = span_q;
    cr_wr = 1'b0; cr_wdata = '0; ov_d = 1'b0; o_d = o_q;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          unique case (in_i.action)
            ActClear: begin cnt_d = '0; st_d = StDone; end
            ActAdd: begin
              if (cnt_q < CntBits'(MaxVertices)) cnt_d = cnt_q + 1'b1;
              st_d = StDone;
            end
            ActFill: begin
              yrow_d = in_i.y_coord; ei_d = '0; k_d = '0;
              st_d = (cnt_q < CntBits'(2)) ? StDone : StRd0;
            end
            default: st_d = StDone;
          endcase
        end
      end
      StRd0: st_d = StRdA;
      StRdA: begin x0_d = rx_q; y0_d = ry_q; st_d = StRd1; end
      StRd1: st_d = StEdge;
      StEdge: begin
        if (crosses) begin
          st_d = StDiv;
        end else if (CntBits'(ei_q) + 1'b1 == cnt_q) begin
          si_d = '0; sj_d = '0; st_d = StSort;
        end else begin
          ei_d = ei_q + 1'b1; st_d = StRd0;
        end
      end
      StDiv: begin
        if (done_div) begin
          cr_wr = 1'b1;
          cr_wdata = x0_q + quot[CoordBits-1:0];
          k_d = k_q + 1'b1;
          if (CntBits'(ei_q) + 1'b1 == cnt_q) begin
            si_d = '0; sj_d = '0; st_d = StSort;
          end else begin
            ei_d = ei_q + 1'b1; st_d = StRd0;
          end
        end
      end
      StSort: begin
        if (k_q < CntBits'(2) || si_q + 1'b1 >= k_q) begin
          span_d = '0;
          st_d = (k_q < CntBits'(2)) ? StDone : StEmit;
        end else if (sj_q + 2'd2 >= k_q - si_q) begin
          sj_d = '0; si_d = si_q + 1'b1;
        end else begin
          sj_d = sj_q + 1'b1;
        end
      end
      StEmit: begin
        ov_d = 1'b1;
        o_d.row = yrow_q;
        o_d.x_start = cr_q[{span_q[IdxBits-2:0], 1'b0}];
        o_d.x_end = cr_q[{span_q[IdxBits-2:0], 1'b1}];
        o_d.last_span = (span_q + 1'b1 == nspan);
        span_d = span_q + 1'b1;
        if (span_q + 1'b1 == nspan) st_d = StDone;
      end
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cr_wr) cr_q[k_q[IdxBits-1:0]] <= cr_wdata;
    if (sw_en) begin
      cr_q[sj_q[IdxBits-1:0]] <= cr_q[sj_q[IdxBits-1:0]+1'b1];
      cr_q[sj_q[IdxBits-1:0]+1'b1] <= cr_q[sj_q[IdxBits-1:0]];
    end
    yrow_q <= yrow_d; x0_q <= x0_d; y0_q <= y0_d; o_q <= o_d;
    si_q <= si_d; sj_q <= sj_d; span_q <= span_d; ei_q <= ei_d; k_q <= k_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ov_q <= ov_d;
    end
  end

  assign busy_o = (st_q != StIdle);
  assign out_valid_o = ov_q;
  assign out_o = o_q;
endmodule
